// ===== rtl/lbr_pkg.sv =====
`default_nettype none

package lbr_pkg;

  localparam int TableDepth = 32;
  localparam int TableAddrW = $clog2(TableDepth);
  localparam int CycleLen   = 255;
  localparam int GenSteps   = 249;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 8;

  localparam logic [CfgIndexW-1:0] RegTapMask    = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] RegStartState = CfgIndexW'(1);

  localparam logic [7:0] TapMaskReset    = 8'd184;
  localparam logic [7:0] StartStateReset = 8'd255;

  typedef struct packed {
    logic [7:0] data_in;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       end_out;
  } out_item_t;

  function automatic logic [7:0] flip_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lbr_ram.sv =====
`default_nettype none

module lbr_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfsr_byte_randomizer_unit.sv =====
// an input transfer is registered in stage 1, then in the result register that drives out_valid
// throughput: one byte per cycle when not stalled, limited by each ram read port
// reset and every write to the tap mask or start state rebuild the sequence table:
// one lfsr step per cycle, 249 steps in all, with in_ready low meanwhile
// reset loads tap mask 184, start state 255 and restarts the bit position at 0
`default_nettype none

module lfsr_byte_randomizer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lbr_pkg::CfgIndexW-1:0]   cfg_index,
  input  wire logic [lbr_pkg::CfgDataW-1:0]    cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lbr_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lbr_pkg::out_item_t                   out_data
);
  import lbr_pkg::*;

  typedef enum logic [1:0] {
    ST_BUILD = 2'b01,
    ST_RUN   = 2'b10
  } gen_state_t;

  gen_state_t state;
  logic [7:0] tap_mask;
  logic [7:0] start_state;
  logic [7:0] lfsr;
  logic [7:0] gen_step;
  logic [7:0] bit_position;
  logic [7:0] bit_position_next;
  logic [8:0] pos_sum;

  logic       cfg_hit;
  logic [7:0] seed_next;

  logic                  tbl_we;
  logic [TableAddrW-1:0] tbl_waddr;
  logic [7:0]            tbl_wdata;
  logic [TableAddrW-1:0] rd_idx_hi;
  logic [TableAddrW-1:0] rd_idx_lo;
  logic [7:0]            hi_byte;
  logic [7:0]            lo_byte;

  logic       in_fire;
  logic       s1_valid;
  logic       s1_move;
  logic [7:0] s1_data;
  logic       s1_end;
  logic [2:0] s1_off;
  logic [15:0] pair_shift;

  // register decode
  always_comb begin
    cfg_hit   = 1'b0;
    seed_next = start_state;
    unique case (cfg_index)
      RegTapMask: begin
        cfg_hit = cfg_we;
      end
      RegStartState: begin
        cfg_hit   = cfg_we;
        seed_next = cfg_wdata[7:0];
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_mask    <= TapMaskReset;
      start_state <= StartStateReset;
    end else if (cfg_hit) begin
      if (cfg_index == RegTapMask) begin
        tap_mask <= cfg_wdata[7:0];
      end else begin
        start_state <= cfg_wdata[7:0];
      end
    end
  end

  // table generator
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_BUILD;
      gen_step <= '0;
      lfsr     <= StartStateReset;
    end else if (cfg_hit) begin
      state    <= ST_BUILD;
      gen_step <= '0;
      lfsr     <= seed_next;
    end else begin
      unique case (state)
        ST_BUILD: begin
          lfsr     <= {^(lfsr & tap_mask), lfsr[7:1]};
          gen_step <= gen_step + 8'd1;
          if (gen_step == 8'(GenSteps - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_BUILD;
        end
      endcase
    end
  end

  assign tbl_we    = (state == ST_BUILD) && (gen_step[2:0] == 3'd0);
  assign tbl_waddr = gen_step[7:3];
  assign tbl_wdata = flip_byte(lfsr);

  // input side
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = (state == ST_RUN) && (!s1_valid || s1_move);
  assign in_fire  = in_valid && in_ready;

  assign rd_idx_hi = bit_position[7:3];
  assign rd_idx_lo = rd_idx_hi + TableAddrW'(1);

  assign pos_sum = {1'b0, bit_position} + 9'd8;
  always_comb begin
    if (in_data.end_of_buffer) begin
      bit_position_next = '0;
    end else if (pos_sum >= 9'(CycleLen)) begin
      bit_position_next = 8'(pos_sum - 9'(CycleLen));
    end else begin
      bit_position_next = pos_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= '0;
    end else if (in_fire) begin
      bit_position <= bit_position_next;
    end
  end

  lbr_ram #(
    .Width (8),
    .Depth (TableDepth)
  ) u_ram_hi (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (in_fire),
    .raddr (rd_idx_hi),
    .rdata (hi_byte)
  );

  lbr_ram #(
    .Width (8),
    .Depth (TableDepth)
  ) u_ram_lo (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (in_fire),
    .raddr (rd_idx_lo),
    .rdata (lo_byte)
  );

  // stage 1 waits on the table read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data <= in_data.data_in;
      s1_end  <= in_data.end_of_buffer;
      s1_off  <= bit_position[2:0];
    end
  end

  assign pair_shift = {hi_byte, lo_byte} << s1_off;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.data_out <= s1_data ^ pair_shift[15:8];
      out_data.end_out  <= s1_end;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_position < 8'(CycleLen))
    else $error("bit position out of range");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.end_of_buffer |=> bit_position == 8'd0)
    else $error("position not restarted after end of buffer");

  a_no_accept_build: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUILD |-> !in_ready)
    else $error("transfer accepted during table build");

  a_build_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUILD && gen_step == 8'(GenSteps - 1) && !cfg_hit |=> state == ST_RUN)
    else $error("table build did not finish");

  a_s1_drain: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("stage 1 item lost");

endmodule

`default_nettype wire

// ===== verif/lfsr_byte_randomizer_unit_tb.sv =====
`default_nettype none

module lfsr_byte_randomizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbr_pkg::*;

  localparam logic [CfgIndexW-1:0] RegUnusedA = CfgIndexW'(2);
  localparam logic [CfgIndexW-1:0] RegUnusedB = CfgIndexW'(3);

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;

  // scrambler image kept by the testbench
  logic [7:0] taps_q;
  logic [7:0] seed_q;
  logic [7:0] seq_tab [TableDepth];
  logic [7:0] bit_pos;

  out_item_t  expected_out [$];
  out_item_t  want_out;
  int         err_count = 0;
  int         hold_left = 0;
  int         hold_request = 0;
  bit         send_idle_en = 1'b1;
  bit         recv_stall_en = 1'b1;

  lfsr_byte_randomizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // lfsr walk, every eighth state stored bit-reversed
  function automatic void rebuild_sequence();
    logic [7:0] lfsr;
    lfsr = seed_q;
    for (int s = 0; s < GenSteps; s++) begin
      if (s % 8 == 0) begin
        for (int k = 0; k < 8; k++) begin
          seq_tab[s / 8][7 - k] = lfsr[k];
        end
      end
      lfsr = {^(lfsr & taps_q), lfsr[7:1]};
    end
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegTapMask: begin
        taps_q = val;
        rebuild_sequence();
      end
      RegStartState: begin
        seed_q = val;
        rebuild_sequence();
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] d, input logic eob);
    in_item_t    item;
    out_item_t   want;
    logic [15:0] window;
    logic [4:0]  row;
    logic [7:0]  p;
    int          np;
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item.data_in = d;
    item.end_of_buffer = eob;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = (bit_pos >= CycleLen) ? 8'd0 : bit_pos;
    row = p[7:3];
    window = {seq_tab[row], seq_tab[row + 5'd1]} << p[2:0];
    want.data_out = d ^ window[15:8];
    want.end_out = eob;
    expected_out.push_back(want);
    np = p + 8;
    if (np >= CycleLen) np = np - CycleLen;
    bit_pos = eob ? 8'd0 : np[7:0];
  endtask

  task automatic send_buffer(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  // output side: checks each transfer, then picks out_ready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual data_out %02h end_out %0b",
                   $time, out_data.data_out, out_data.end_out);
          err_count++;
        end else begin
          want_out = expected_out.pop_front();
          if (out_data.data_out !== want_out.data_out) begin
            $display("%0t data_out mismatch: expected %02h, actual %02h",
                     $time, want_out.data_out, out_data.data_out);
            err_count++;
          end
          if (out_data.end_out !== want_out.end_out) begin
            $display("%0t end_out mismatch: expected %0b, actual %0b",
                     $time, want_out.end_out, out_data.end_out);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request > 0) begin
        hold_left = hold_request - 1;
        hold_request = 0;
        out_ready <= 1'b0;
      end else if (recv_stall_en && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_sequence();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h0F, 1'b1);
    wait_drained();
  endtask

  // zero seed gives an all-zero table, bytes pass straight through
  task automatic test_zero_seed();
    write_reg(RegStartState, 8'h00);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();
  endtask

  // buffer left open across the tap mask write, position must carry over
  task automatic test_zero_taps();
    write_reg(RegStartState, 8'hFF);
    send_byte(8'hA5, 1'b0);
    wait_drained();
    write_reg(RegTapMask, 8'h00);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_extreme_config();
    write_reg(RegTapMask, 8'hFF);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    wait_drained();
    write_reg(RegStartState, 8'h01);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
    wait_drained();
  endtask

  task automatic test_unused_index();
    write_reg(RegUnusedA, 8'h00);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    wait_drained();
    write_reg(RegUnusedB, 8'hFF);
    send_byte(8'hED, 1'b0);
    send_byte(8'hCB, 1'b1);
    wait_drained();
  endtask

  // random settings per phase, mostly short buffers, a few that wrap the table
  task automatic test_random_buffers();
    int             sent;
    int             len;
    logic [CfgDataW-1:0] val;
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: val = '0;
        1: val = '1;
        default: val = CfgDataW'($urandom_range(0, 255));
      endcase
      write_reg(CfgIndexW'($urandom_range(0, 3)), val);
      sent = 0;
      while (sent < 50) begin
        if (ph == 3 && sent == 0) len = $urandom_range(240, 300);
        else len = $urandom_range(1, 40);
        send_buffer(len);
        sent += len;
      end
      // sometimes leave a buffer open over the next write
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i < 3; i++) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_en = 1'b0;
    hold_request = 80;
    send_buffer(25);
    send_buffer(15);
    wait_drained();
    send_idle_en = 1'b1;
  endtask

  task automatic test_full_rate();
    send_idle_en = 1'b0;
    recv_stall_en = 1'b0;
    write_reg(RegTapMask, 8'($urandom_range(0, 255)));
    send_buffer(60);
    send_buffer(90);
    wait_drained();
  endtask

  initial begin
    taps_q = TapMaskReset;
    seed_q = StartStateReset;
    bit_pos = '0;
    rebuild_sequence();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_sequence();
    test_zero_seed();
    test_zero_taps();
    test_extreme_config();
    test_unused_index();
    test_random_buffers();
    test_output_backpressure();
    test_full_rate();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_out.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
